### sv/ffba_pkg.sv
// Package for the first-fit boundary-tag allocator: payload structs, codes,
// sequencer states and the heap memory request bundle. Depends on nothing.
package ffba_pkg;

    localparam int HEAP_WORDS_DEF = 16384;
    localparam int CHUNK_W        = 17;
    localparam int BA_W           = 18;
    localparam int ADDR_SPAN      = 65536;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'd4096;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_INIT  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_NOINIT  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] request_bytes;
        logic [15:0] block_addr;
    } ffba_req_t;

    typedef struct packed {
        logic [15:0] payload_addr;
        logic [1:0]  status;
    } ffba_rsp_t;

    typedef struct packed {
        logic            we;
        logic [BA_W-1:0] waddr;
        logic [31:0]     wdata;
        logic            re;
        logic [BA_W-1:0] raddr;
    } ffba_ram_req_t;

    typedef enum logic [1:0] {
        CTX_INIT,
        CTX_ALLOC,
        CTX_REL
    } ctx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_GROW_CHK,
        S_GROW_W0,
        S_GROW_W1,
        S_GROW_W2,
        S_MRG_RD_PREV,
        S_MRG_RD_NEXT,
        S_MRG_EVAL,
        S_MRG_PH,
        S_MRG_NF,
        S_MRG_W0,
        S_MRG_W1,
        S_MRG_END,
        S_FIT_RD,
        S_FIT,
        S_PLACE_RD,
        S_PLACE_EV,
        S_PL_W0,
        S_PL_W1,
        S_PL_W2,
        S_PL_W3,
        S_REL_RD,
        S_REL_EV,
        S_REL_W0,
        S_REL_W1,
        S_FINISH
    } state_t;

endpackage

### sv/first_fit_boundary_tag_allocator.sv
// Top level of the first-fit boundary-tag heap allocator: sequencer and tag datapath.
// Depends on ffba_pkg and ffba_heap_ram.
//
// The block keeps a heap of 4-byte tag words in one synchronous memory and serves one
// request at a time: initialize, allocate or release. Each transfer on the request
// channel yields exactly one transfer on the response channel. An initialize runs four
// setup writes, the growth check, three tag writes, a merge and the finish cycle. An
// allocate reads the first header and walks the block headers one by one in the
// first-fit search, then places the block and finishes; when no block fits, a growth
// (check, three tag writes and a merge) is added. A release reads and checks the tag,
// writes the two tags and then merges. The walk and the merge each wait on one tag
// word per read from the single read port of the heap memory. The finish cycle repeats
// for as long as an earlier response still waits on the response channel. A new
// request is taken as soon as the sequencer is idle, even while the previous response
// still waits on the response channel. The heap memory needs no clearing after reset.
module first_fit_boundary_tag_allocator #(
    parameter int HEAP_WORDS = ffba_pkg::HEAP_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  ffba_pkg::ffba_req_t            req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output ffba_pkg::ffba_rsp_t            rsp_data,
    input  logic                           cfg_wr_en,
    input  logic [ffba_pkg::CHUNK_W-1:0]   cfg_wr_data
);
    import ffba_pkg::*;

    // Usable heap is bounded both by the memory and by the 16-bit address space.
    localparam int USABLE_I = (HEAP_WORDS * 4 > ADDR_SPAN) ? ADDR_SPAN : HEAP_WORDS * 4;
    localparam logic [BA_W:0] USABLE = (BA_W + 1)'(USABLE_I);

    state_t state_reg, state_next;
    ctx_t   ctx_reg, ctx_next;

    logic [BA_W-1:0]    bp_reg, bp_next;
    logic [BA_W-1:0]    size_reg, size_next;
    logic [BA_W-1:0]    psize_reg, psize_next;
    logic [BA_W-1:0]    wa0_reg, wa0_next;
    logic [BA_W-1:0]    wa1_reg, wa1_next;
    logic [CHUNK_W-1:0] asize_reg, asize_next;
    logic [CHUNK_W-1:0] break_reg, break_next;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic               prevu_reg, prevu_next;
    logic               both_free_reg, both_free_next;
    logic               split_reg, split_next;
    logic               ready_reg, ready_next;
    logic [15:0]        res_addr_reg, res_addr_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               rsp_valid_reg, rsp_valid_next;
    ffba_rsp_t          rsp_data_reg, rsp_data_next;

    ffba_ram_req_t ram_req;
    logic [31:0]   ram_rdata;

    ffba_heap_ram #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_ram (
        .clk     (clk),
        .ram_req (ram_req),
        .rdata   (ram_rdata)
    );

    // Decoded tag word from the memory read port.
    logic [BA_W-1:0] q_size;
    logic            q_used;
    assign q_size = {1'b0, ram_rdata[16:3], 3'b000};
    assign q_used = ram_rdata[0];

    logic acc;
    assign acc       = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // The chunk register is rounded to the nearest multiple of 8 bytes (halves up) and to at least 8.
    logic [14:0]     chunk_q;
    logic [BA_W-1:0] chunk_round;
    always_comb
    begin
        chunk_q     = {1'b0, chunk_reg[16:3]} + 15'(chunk_reg[2]);
        chunk_round = (chunk_q == 15'd0) ? BA_W'(8) : {chunk_q, 3'b000};
    end

    // Request size: payload rounded to 8 bytes plus the two tags, at least 16.
    logic [16:0]        req_sum;
    logic [CHUNK_W-1:0] asize_calc;
    always_comb
    begin
        req_sum    = {1'b0, req_data.request_bytes} + 17'd15;
        asize_calc = (req_data.request_bytes <= 16'd8) ? 17'd16 : {req_sum[16:3], 3'b000};
    end

    logic rel_pre_ok;
    assign rel_pre_ok = (req_data.block_addr[2:0] == 3'd0) && (req_data.block_addr >= 16'd16)
                        && ({1'b0, req_data.block_addr} < break_reg);

    logic [BA_W:0]   grow_sum;
    logic            grow_ok;
    logic [BA_W-1:0] fit_bpn;
    logic            fit_hit;
    logic            fit_more;
    logic            place_split;
    logic            rel_ok;
    logic            slot_free;
    always_comb
    begin
        grow_sum    = {2'b00, break_reg} + {1'b0, size_reg};
        grow_ok     = grow_sum <= USABLE;
        fit_bpn     = bp_reg + q_size;
        fit_hit     = (q_size != '0) && !q_used && ({1'b0, asize_reg} <= q_size);
        fit_more    = (q_size != '0) && !fit_hit
                      && ((fit_bpn - BA_W'(4)) < {1'b0, break_reg});
        place_split = {1'b0, q_size} >= ({2'b00, asize_reg} + (BA_W + 1)'(16));
        rel_ok      = q_used && (q_size != '0)
                      && (({1'b0, bp_reg} + {1'b0, q_size}) <= {2'b00, break_reg});
        slot_free   = !rsp_valid_reg || rsp_ready;
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    unique case (req_data.kind)
                        KIND_INIT:  state_next = S_INIT;
                        KIND_ALLOC: state_next = (!ready_reg || req_data.request_bytes == '0)
                                                 ? S_FINISH : S_FIT_RD;
                        KIND_FREE:  state_next = (ready_reg && rel_pre_ok) ? S_REL_RD : S_FINISH;
                        default:    state_next = S_FINISH;
                    endcase
                end
            end
            S_INIT:        state_next = (cnt_reg == 2'd3) ? S_GROW_CHK : S_INIT;
            S_GROW_CHK:    state_next = grow_ok ? S_GROW_W0 : S_FINISH;
            S_GROW_W0:     state_next = S_GROW_W1;
            S_GROW_W1:     state_next = S_GROW_W2;
            S_GROW_W2:     state_next = S_MRG_RD_PREV;
            S_MRG_RD_PREV: state_next = S_MRG_RD_NEXT;
            S_MRG_RD_NEXT: state_next = S_MRG_EVAL;
            S_MRG_EVAL:
            begin
                if (prevu_reg && q_used)
                begin
                    state_next = S_MRG_END;
                end
                else if (prevu_reg)
                begin
                    state_next = S_MRG_W0;
                end
                else
                begin
                    state_next = S_MRG_PH;
                end
            end
            S_MRG_PH:      state_next = both_free_reg ? S_MRG_NF : S_MRG_W0;
            S_MRG_NF:      state_next = S_MRG_W0;
            S_MRG_W0:      state_next = S_MRG_W1;
            S_MRG_W1:      state_next = S_MRG_END;
            S_MRG_END:     state_next = (ctx_reg == CTX_ALLOC) ? S_PLACE_RD : S_FINISH;
            S_FIT_RD:      state_next = S_FIT;
            S_FIT:
            begin
                if (fit_hit)
                begin
                    state_next = S_PLACE_RD;
                end
                else if (fit_more)
                begin
                    state_next = S_FIT;
                end
                else
                begin
                    state_next = S_GROW_CHK;
                end
            end
            S_PLACE_RD:    state_next = S_PLACE_EV;
            S_PLACE_EV:    state_next = S_PL_W0;
            S_PL_W0:       state_next = S_PL_W1;
            S_PL_W1:       state_next = split_reg ? S_PL_W2 : S_FINISH;
            S_PL_W2:       state_next = S_PL_W3;
            S_PL_W3:       state_next = S_FINISH;
            S_REL_RD:      state_next = S_REL_EV;
            S_REL_EV:      state_next = rel_ok ? S_REL_W0 : S_FINISH;
            S_REL_W0:      state_next = S_REL_W1;
            S_REL_W1:      state_next = S_MRG_RD_PREV;
            S_FINISH:      state_next = slot_free ? S_IDLE : S_FINISH;
            default:       state_next = S_IDLE;
        endcase
    end

    // Datapath updates and memory requests for each state.
    always_comb
    begin
        ctx_next        = ctx_reg;
        bp_next         = bp_reg;
        size_next       = size_reg;
        psize_next      = psize_reg;
        wa0_next        = wa0_reg;
        wa1_next        = wa1_reg;
        asize_next      = asize_reg;
        break_next      = break_reg;
        cnt_next        = cnt_reg;
        prevu_next      = prevu_reg;
        both_free_next  = both_free_reg;
        split_next      = split_reg;
        ready_next      = ready_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        ram_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    res_addr_next   = '0;
                    res_status_next = ST_OK;
                    cnt_next        = '0;
                    unique case (req_data.kind)
                        KIND_INIT:
                        begin
                            ctx_next = CTX_INIT;
                        end
                        KIND_ALLOC:
                        begin
                            ctx_next   = CTX_ALLOC;
                            asize_next = asize_calc;
                            bp_next    = BA_W'(8);
                            if (!ready_reg)
                            begin
                                res_status_next = ST_NOINIT;
                            end
                            else if (req_data.request_bytes == '0)
                            begin
                                res_status_next = ST_ZERO;
                            end
                        end
                        KIND_FREE:
                        begin
                            ctx_next = CTX_REL;
                            bp_next  = {2'b00, req_data.block_addr};
                            if (!ready_reg)
                            begin
                                res_status_next = ST_NOINIT;
                            end
                        end
                        default:
                        begin
                            ctx_next = ctx_reg;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                // Padding word, prologue header and footer, then the epilogue.
                ram_req.we    = 1'b1;
                ram_req.waddr = {14'd0, cnt_reg, 2'b00};
                case (cnt_reg)
                    2'd0:    ram_req.wdata = 32'd0;
                    2'd3:    ram_req.wdata = 32'd1;
                    default: ram_req.wdata = 32'd9;
                endcase
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    break_next = 17'd16;
                    size_next  = chunk_round;
                end
            end
            S_GROW_CHK:
            begin
                if (grow_ok)
                begin
                    bp_next    = {1'b0, break_reg};
                    break_next = grow_sum[CHUNK_W-1:0];
                end
                else
                begin
                    res_status_next = ST_NOSPACE;
                    if (ctx_reg == CTX_INIT)
                    begin
                        ready_next = 1'b0;
                    end
                end
            end
            S_GROW_W0:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = bp_reg - BA_W'(4);
                ram_req.wdata = 32'(size_reg);
            end
            S_GROW_W1:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = bp_reg + size_reg - BA_W'(8);
                ram_req.wdata = 32'(size_reg);
            end
            S_GROW_W2:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = bp_reg + size_reg - BA_W'(4);
                ram_req.wdata = 32'd1;
            end
            S_MRG_RD_PREV:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = bp_reg - BA_W'(8);
            end
            S_MRG_RD_NEXT:
            begin
                prevu_next    = q_used;
                psize_next    = q_size;
                ram_req.re    = 1'b1;
                ram_req.raddr = bp_reg + size_reg - BA_W'(4);
            end
            S_MRG_EVAL:
            begin
                if (prevu_reg && !q_used)
                begin
                    size_next = size_reg + q_size;
                    wa0_next  = bp_reg - BA_W'(4);
                    wa1_next  = bp_reg + size_reg + q_size - BA_W'(8);
                end
                else if (!prevu_reg)
                begin
                    // The block moves down to the start of the free block below it.
                    bp_next       = bp_reg - psize_reg;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = bp_reg - psize_reg - BA_W'(4);
                    if (q_used)
                    begin
                        both_free_next = 1'b0;
                        wa0_next       = bp_reg + size_reg - BA_W'(8);
                        wa1_next       = bp_reg - psize_reg - BA_W'(4);
                    end
                    else
                    begin
                        both_free_next = 1'b1;
                        wa0_next       = bp_reg - psize_reg - BA_W'(4);
                        wa1_next       = bp_reg + size_reg + q_size - BA_W'(8);
                    end
                end
            end
            S_MRG_PH:
            begin
                size_next = size_reg + q_size;
                if (both_free_reg)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = wa1_reg;
                end
            end
            S_MRG_NF:
            begin
                size_next = size_reg + q_size;
            end
            S_MRG_W0:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = wa0_reg;
                ram_req.wdata = 32'(size_reg);
            end
            S_MRG_W1:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = wa1_reg;
                ram_req.wdata = 32'(size_reg);
            end
            S_MRG_END:
            begin
                if (ctx_reg == CTX_INIT)
                begin
                    ready_next = 1'b1;
                end
            end
            S_FIT_RD:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = bp_reg - BA_W'(4);
            end
            S_FIT:
            begin
                if (!fit_hit && fit_more)
                begin
                    bp_next       = fit_bpn;
                    ram_req.re    = 1'b1;
                    ram_req.raddr = fit_bpn - BA_W'(4);
                end
                else if (!fit_hit)
                begin
                    size_next = ({1'b0, asize_reg} > chunk_round) ? {1'b0, asize_reg}
                                                                  : chunk_round;
                end
            end
            S_PLACE_RD:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = bp_reg - BA_W'(4);
            end
            S_PLACE_EV:
            begin
                size_next     = q_size;
                split_next    = place_split;
                res_addr_next = bp_reg[15:0];
            end
            S_PL_W0:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = bp_reg - BA_W'(4);
                ram_req.wdata = split_reg ? (32'(asize_reg) | 32'd1) : (32'(size_reg) | 32'd1);
            end
            S_PL_W1:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = split_reg ? (bp_reg + BA_W'(asize_reg) - BA_W'(8))
                                          : (bp_reg + size_reg - BA_W'(8));
                ram_req.wdata = split_reg ? (32'(asize_reg) | 32'd1) : (32'(size_reg) | 32'd1);
            end
            S_PL_W2:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = bp_reg + BA_W'(asize_reg) - BA_W'(4);
                ram_req.wdata = 32'(size_reg - BA_W'(asize_reg));
            end
            S_PL_W3:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = bp_reg + size_reg - BA_W'(8);
                ram_req.wdata = 32'(size_reg - BA_W'(asize_reg));
            end
            S_REL_RD:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = bp_reg - BA_W'(4);
            end
            S_REL_EV:
            begin
                size_next = q_size;
            end
            S_REL_W0:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = bp_reg - BA_W'(4);
                ram_req.wdata = 32'(size_reg);
            end
            S_REL_W1:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = bp_reg + size_reg - BA_W'(8);
                ram_req.wdata = 32'(size_reg);
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_data_next.payload_addr = res_addr_reg;
                    rsp_data_next.status       = res_status_reg;
                end
            end
            default:
            begin
                ram_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            break_reg     <= '0;
            ready_reg     <= 1'b0;
            chunk_reg     <= CHUNK_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            break_reg     <= break_next;
            ready_reg     <= ready_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                chunk_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg        <= ctx_next;
        bp_reg         <= bp_next;
        size_reg       <= size_next;
        psize_reg      <= psize_next;
        wa0_reg        <= wa0_next;
        wa1_reg        <= wa1_next;
        asize_reg      <= asize_next;
        cnt_reg        <= cnt_next;
        prevu_reg      <= prevu_next;
        both_free_reg  <= both_free_next;
        split_reg      <= split_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        rsp_data_reg   <= rsp_data_next;
    end

endmodule

### sv/ffba_heap_ram.sv
// Heap word memory for the allocator: one write port, one registered read port.
// Depends on ffba_pkg for the request bundle.
module ffba_heap_ram #(
    parameter int HEAP_WORDS = ffba_pkg::HEAP_WORDS_DEF
) (
    input  logic                  clk,
    input  ffba_pkg::ffba_ram_req_t ram_req,
    output logic [31:0]           rdata
);
    import ffba_pkg::*;

    localparam int AW = $clog2(HEAP_WORDS);

    logic [31:0] mem [HEAP_WORDS];

    // Byte addresses are turned into word indexes here.
    always_ff @(posedge clk)
    begin
        if (ram_req.we)
        begin
            mem[AW'(ram_req.waddr >> 2)] <= ram_req.wdata;
        end
        if (ram_req.re)
        begin
            rdata <= mem[AW'(ram_req.raddr >> 2)];
        end
    end

endmodule

### sv/ffba_checker.sv
// Port-level checker for the first-fit boundary-tag allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_boundary_tag_allocator.
module ffba_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input ffba_pkg::ffba_rsp_t          rsp_data
);
    import ffba_pkg::*;

    // A stalled response keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

    // Failed requests return no address.
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != ST_OK |-> rsp_data.payload_addr == 16'd0)
        else $error("failed request returned an address");

    // A returned payload address is 8-byte aligned and above the prologue.
    a_addr_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.payload_addr != 16'd0
        |-> rsp_data.payload_addr[2:0] == 3'd0 && rsp_data.payload_addr >= 16'd16)
        else $error("payload address misaligned or inside the prologue");

endmodule

bind first_fit_boundary_tag_allocator ffba_checker u_ffba_checker (.*);
